### rtl/csrse_pkg.sv
// Shared constants and codes for the sparse element store.
`timescale 1ns / 1ps
package csrse_pkg;

  localparam int MAX_NNZ_DEF   = 1024;
  localparam int MAX_LINES_DEF = 256;

  localparam int VALUE_W  = 64;
  localparam int COORD_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MINOR_MAX = 256;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_VALUE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_SET    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_COUNT = 2'd2;

endpackage

### rtl/csrse_in_if.sv
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
interface csrse_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [63:0] write_value;

  modport source (output valid, action, row, col, write_value, input ready);
  modport sink   (input valid, action, row, col, write_value, output ready);
endinterface

interface csrse_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] read_value;
  logic [10:0] stored_count;

  modport source (output valid, status, read_value, stored_count, input ready);
  modport sink   (input valid, status, read_value, stored_count, output ready);
endinterface

### rtl/csrse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module csrse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/csr_sparse_element_store.sv
// Top level of the sparse element store: control sequencer around two RAMs.
`timescale 1ns / 1ps
// Sparse matrix store in compressed row (or column) form. A line-start
// pointer RAM (MAX_LINES+1 words) and an entry RAM (MAX_NNZ words of minor
// index plus 64-bit value) hold the matrix; one request beat is handled at a
// time. After reset the block sweeps zeros through all MAX_LINES+1 pointer
// RAM words and takes no request beat meanwhile (configuration writes still
// land). A zero-value set or an out-of-range request is refused straight
// after the accept. Otherwise the block takes the beat and fetches the line
// bounds, then walks the line, reading each entry from the entry RAM and
// then comparing it; a walk that runs off the end of the line or passes the
// minor index settles a miss, and the result is handed over last. An insert
// shifts each later entry up, writes the new entry and increments every
// following line pointer, all through the single RAM ports. A finished
// result sits in an output register, so the next request is taken while
// the previous result waits to be drained; the block stalls only when a
// second result is ready before the first has left.
module csr_sparse_element_store #(
  parameter int MAX_NNZ   = csrse_pkg::MAX_NNZ_DEF,
  parameter int MAX_LINES = csrse_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [csrse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csrse_pkg::CFG_W-1:0]         cfg_wdata,
  csrse_in_if.sink                            in_ch,
  csrse_out_if.source                         out_ch
);
  import csrse_pkg::*;

  localparam int CW  = $clog2(MAX_NNZ + 1);
  localparam int AW  = $clog2(MAX_NNZ);
  localparam int LAW = $clog2(MAX_LINES + 1);
  localparam int DW  = COORD_W + VALUE_W;
  localparam logic [LAW-1:0] LAST_LINE = LAW'(MAX_LINES);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(MAX_NNZ);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RS   = 4'd2;
  localparam logic [3:0] S_RE   = 4'd3;
  localparam logic [3:0] S_RC   = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_WCHK = 4'd6;
  localparam logic [3:0] S_NF   = 4'd7;
  localparam logic [3:0] S_SHRD = 4'd8;
  localparam logic [3:0] S_SHWR = 4'd9;
  localparam logic [3:0] S_INS  = 4'd10;
  localparam logic [3:0] S_PRD  = 4'd11;
  localparam logic [3:0] S_PWR  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]          state_r, state_nxt;
  logic                act_r, act_nxt;
  logic [COORD_W-1:0]  major_r, major_nxt, minor_r, minor_nxt;
  logic [VALUE_W-1:0]  wv_r, wv_nxt;
  logic [CW-1:0]       s_r, s_nxt, e_r, e_nxt, i_r, i_nxt, p_r, p_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [LAW-1:0]      j_r, j_nxt;
  logic                mo_r;
  logic [CFG_W-1:0]    lc_r, mc_r;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [VALUE_W-1:0]  res_val_r, res_val_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_st_r;
  logic [VALUE_W-1:0]  out_val_r;
  logic [COUNT_W-1:0]  out_cnt_r;

  // Pointer RAM ports.
  logic           ls_we;
  logic [LAW-1:0] ls_waddr, ls_raddr;
  logic [CW-1:0]  ls_wdata, ls_rdata;
  // Entry RAM ports.
  logic           d_we;
  logic [AW-1:0]  d_waddr, d_raddr;
  logic [DW-1:0]  d_wdata, d_rdata;

  logic [COORD_W-1:0] in_major, in_minor, d_minor;
  logic               in_take, out_load, range_bad;
  logic [CW-1:0]      im1, e_clamp;

  csrse_ram #(.WIDTH(CW), .DEPTH(MAX_LINES + 1)) u_line_start (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  csrse_ram #(.WIDTH(DW), .DEPTH(MAX_NNZ)) u_entries (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.read_value   = out_val_r;
  assign out_ch.stored_count = out_cnt_r;

  // Map coordinates onto major/minor by storage order.
  assign in_major = mo_r ? in_ch.col : in_ch.row;
  assign in_minor = mo_r ? in_ch.row : in_ch.col;

  // A count of zero behaves as one; line count caps at MAX_LINES.
  always_comb begin
    range_bad = 1'b0;
    if (lc_r == '0) begin
      if (in_major != '0) range_bad = 1'b1;
    end else if ({1'b0, in_major} >= lc_r) begin
      range_bad = 1'b1;
    end
    if (32'(in_major) >= 32'(MAX_LINES)) range_bad = 1'b1;
    if (mc_r == '0) begin
      if (in_minor != '0) range_bad = 1'b1;
    end else if ({1'b0, in_minor} >= mc_r) begin
      range_bad = 1'b1;
    end
  end

  assign im1     = i_r - 1'b1;
  assign d_minor = d_rdata[DW-1:VALUE_W];
  assign e_clamp = (ls_rdata > total_r) ? total_r : ls_rdata;

  always_comb begin
    ls_raddr = j_r;
    unique case (state_r)
      S_RS:    ls_raddr = LAW'(major_r);
      S_RE:    ls_raddr = LAW'(major_r) + 1'b1;
      default: ls_raddr = j_r;
    endcase
    ls_we    = (state_r == S_CLR) || (state_r == S_PWR);
    ls_waddr = j_r;
    ls_wdata = (state_r == S_CLR) ? '0 : ls_rdata + 1'b1;

    d_raddr = (state_r == S_SHRD) ? im1[AW-1:0] : i_r[AW-1:0];
    d_we    = 1'b0;
    d_waddr = i_r[AW-1:0];
    d_wdata = {minor_r, wv_r};
    if (state_r == S_WCHK && d_minor == minor_r && act_r == ACT_SET) begin
      d_we = 1'b1;
    end
    if (state_r == S_SHWR) begin
      d_we    = 1'b1;
      d_wdata = d_rdata;
    end
    if (state_r == S_INS) begin
      d_we    = 1'b1;
      d_waddr = p_r[AW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    wv_nxt      = wv_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    i_nxt       = i_r;
    p_nxt       = p_r;
    j_nxt       = j_r;
    total_nxt   = total_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    unique case (state_r)
      S_CLR: begin
        // Sweep zeros through the pointer RAM.
        j_nxt = j_r + 1'b1;
        if (j_r == LAST_LINE) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_take) begin
          act_nxt     = in_ch.action;
          major_nxt   = in_major;
          minor_nxt   = in_minor;
          wv_nxt      = in_ch.write_value;
          res_val_nxt = '0;
          if (in_ch.action == ACT_SET && in_ch.write_value == '0) begin
            res_st_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else if (range_bad) begin
            res_st_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RS;
          end
        end
      end
      S_RS: state_nxt = S_RE;
      S_RE: begin
        s_nxt     = ls_rdata;
        state_nxt = S_RC;
      end
      S_RC: begin
        e_nxt     = e_clamp;
        i_nxt     = (s_r > e_clamp) ? e_clamp : s_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (i_r >= e_r) begin
          p_nxt     = i_r;
          state_nxt = S_NF;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (d_minor == minor_r) begin
          // Hit: lookup returns, set overwrites in place.
          res_st_nxt = ST_OK;
          if (act_r == ACT_LOOKUP) res_val_nxt = d_rdata[VALUE_W-1:0];
          state_nxt = S_DONE;
        end else if (minor_r < d_minor) begin
          p_nxt     = i_r;
          state_nxt = S_NF;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_NF: begin
        if (act_r == ACT_LOOKUP) begin
          res_st_nxt = ST_NO_VALUE;
          state_nxt  = S_DONE;
        end else if (total_r >= FULL_CNT) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          i_nxt     = total_r;
          state_nxt = (total_r > p_r) ? S_SHRD : S_INS;
        end
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: begin
        // Move entry i-1 up to i, then advance downward.
        i_nxt     = im1;
        state_nxt = (im1 > p_r) ? S_SHRD : S_INS;
      end
      S_INS: begin
        j_nxt     = LAW'(major_r) + 1'b1;
        state_nxt = S_PRD;
      end
      S_PRD: state_nxt = S_PWR;
      S_PWR: begin
        if (j_r == LAST_LINE) begin
          total_nxt  = total_r + 1'b1;
          res_st_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      j_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      mo_r        <= 1'b0;
      lc_r        <= CFG_W'(256);
      mc_r        <= CFG_W'(MINOR_MAX);
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      total_r <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAJOR_ORDER: mo_r <= cfg_wdata[0];
          CFG_LINE_COUNT:  lc_r <= cfg_wdata;
          CFG_MINOR_COUNT: mc_r <= cfg_wdata;
          default:         ;
        endcase
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    major_r   <= major_nxt;
    minor_r   <= minor_nxt;
    wv_r      <= wv_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    i_r       <= i_nxt;
    p_r       <= p_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_cnt_r <= COUNT_W'(total_r);
    end
  end
endmodule

### bench/tb.sv
// Self-checking bench for the compressed sparse element store.
`timescale 1ns / 1ps
module tb;
  import csrse_pkg::*;

  typedef struct packed {
    logic        action;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [63:0] write_value;
  } elem_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [10:0] stored_count;
  } elem_res_t;

  localparam int NNZ_CAP    = MAX_NNZ_DEF;
  localparam int LINE_CAP   = MAX_LINES_DEF;
  localparam int CYCLE_CAP  = 20000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  csrse_in_if  in_ch();
  csrse_out_if out_ch();

  csr_sparse_element_store dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow copy of the store and its registers.
  int unsigned line_ptr [0:LINE_CAP];
  logic [7:0]  minor_at [0:NNZ_CAP-1];
  logic [63:0] value_at [0:NNZ_CAP-1];
  int unsigned entry_cnt;
  logic        col_major;
  logic [8:0]  lines_reg;
  logic [8:0]  minors_reg;

  elem_req_t pending_reqs[$];
  elem_res_t expected_res[$];
  int errors;
  int cycles;
  bit in_fire;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asks;
  int hold_done;
  int hold_left;

  // Walk one line; returns 1 on a hit. pos is the hit or the insert point.
  function automatic bit find_in_line(input int unsigned major, input logic [7:0] minor,
                                      output int unsigned pos);
    int unsigned s, e;
    s = line_ptr[major];
    e = line_ptr[major + 1];
    if (e > entry_cnt) e = entry_cnt;
    if (s > e) s = e;
    pos = s;
    for (int unsigned i = s; i < e; i++) begin
      if (minor_at[i] == minor) begin
        pos = i;
        return 1'b1;
      end
      if (minor < minor_at[i]) begin
        pos = i;
        return 1'b0;
      end
      pos = i + 1;
    end
    return 1'b0;
  endfunction

  function automatic elem_res_t apply_to_store(input elem_req_t r);
    elem_res_t res;
    int unsigned major, minor, nlines, nminor, pos;
    major  = col_major ? r.col : r.row;
    minor  = col_major ? r.row : r.col;
    nlines = (lines_reg == 0) ? 1 : (lines_reg > LINE_CAP) ? LINE_CAP : lines_reg;
    nminor = (minors_reg == 0) ? 1 : (minors_reg > MINOR_MAX) ? MINOR_MAX : minors_reg;
    res.read_value = '0;
    if (r.action == ACT_SET && r.write_value == 64'd0) begin
      res.status = ST_ZERO;
    end else if (major >= nlines || minor >= nminor) begin
      res.status = ST_RANGE;
    end else if (r.action == ACT_LOOKUP) begin
      if (find_in_line(major, minor[7:0], pos)) begin
        res.status = ST_OK;
        res.read_value = value_at[pos];
      end else begin
        res.status = ST_NO_VALUE;
      end
    end else if (find_in_line(major, minor[7:0], pos)) begin
      value_at[pos] = r.write_value;
      res.status = ST_OK;
    end else if (entry_cnt >= NNZ_CAP) begin
      res.status = ST_FULL;
    end else begin
      for (int unsigned i = entry_cnt; i > pos; i--) begin
        minor_at[i] = minor_at[i-1];
        value_at[i] = value_at[i-1];
      end
      minor_at[pos] = minor[7:0];
      value_at[pos] = r.write_value;
      for (int unsigned i = major + 1; i <= LINE_CAP; i++) line_ptr[i]++;
      entry_cnt++;
      res.status = ST_OK;
    end
    res.stored_count = entry_cnt[10:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check result beats and predict results of request beats, both at the rising edge.
  always @(posedge clk) begin
    elem_res_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: done, errors");
      $finish;
    end
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.read_value, out_ch.stored_count};
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
    if (in_fire)
      expected_res.push_back(apply_to_store('{in_ch.action, in_ch.row, in_ch.col,
                                              in_ch.write_value}));
  end

  // Request driver: hold the beat until taken, then advance or idle.
  always @(negedge clk) begin
    elem_req_t r;
    logic v;
    v = in_ch.valid;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      v = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        v = 1'b1;
        in_ch.action      <= r.action;
        in_ch.row         <= r.row;
        in_ch.col         <= r.col;
        in_ch.write_value <= r.write_value;
      end
    end
    in_ch.valid <= v;
  end

  // Result sink: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_res.size() != 0 ||
           hold_left != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAJOR_ORDER: col_major  = val[0];
      CFG_LINE_COUNT:  lines_reg  = val;
      CFG_MINOR_COUNT: minors_reg = val;
      default: ;
    endcase
  endtask

  task automatic push(input logic act, input logic [7:0] r, input logic [7:0] c,
                      input logic [63:0] v);
    pending_reqs.push_back('{act, r, c, v});
  endtask

  // Mostly coordinates near the origin so overwrites and hits are common.
  task automatic push_random(input int span);
    logic [63:0] v;
    logic [7:0] r, c;
    int pick;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 10) v = '0;
    else if (pick < 15) v = '1;
    if ($urandom_range(99) < 15) begin
      r = 8'($urandom_range(255));
      c = 8'($urandom_range(255));
    end else begin
      r = 8'($urandom_range(span));
      c = 8'($urandom_range(span));
    end
    push(1'($urandom_range(1)), r, c, v);
  endtask

  initial begin
    logic [8:0] line_opts [6];
    logic [8:0] minor_opts [6];
    line_opts  = '{9'd0, 9'd1, 9'd6, 9'd12, 9'd256, 9'd511};
    minor_opts = '{9'd0, 9'd3, 9'd9, 9'd12, 9'd256, 9'd511};
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks = 0;
    hold_done = 0;
    hold_left = 0;
    in_fire = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAJOR_ORDER;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOOKUP;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i <= LINE_CAP; i++) line_ptr[i] = 0;
    for (int i = 0; i < NNZ_CAP; i++) begin
      minor_at[i] = '0;
      value_at[i] = '0;
    end
    entry_cnt = 0;
    col_major = 1'b0;
    lines_reg = 9'd256;
    minors_reg = 9'd256;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hits, misses, overwrite, zero refusal, corner coordinates.
    push(ACT_LOOKUP, 8'd0, 8'd0, 64'd5);
    push(ACT_SET, 8'd0, 8'd0, '1);
    push(ACT_SET, 8'd0, 8'd0, 64'd1);
    push(ACT_LOOKUP, 8'd0, 8'd0, '0);
    push(ACT_SET, 8'd255, 8'd255, '0);
    push(ACT_SET, 8'd255, 8'd255, 64'h8000_0000_0000_0000);
    push(ACT_LOOKUP, 8'd255, 8'd255, '0);
    push(ACT_SET, 8'd0, 8'd7, 64'h5555_aaaa_5555_aaaa);
    push(ACT_SET, 8'd0, 8'd3, 64'haaaa_5555_aaaa_5555);
    push(ACT_LOOKUP, 8'd0, 8'd3, '0);
    push(ACT_LOOKUP, 8'd0, 8'd4, '0);
    drain();

    // Register counts of zero act as one; zero check comes before range.
    write_reg(CFG_LINE_COUNT, 9'd0);
    write_reg(CFG_MINOR_COUNT, 9'd0);
    push(ACT_SET, 8'd1, 8'd0, 64'd9);
    push(ACT_SET, 8'd0, 8'd1, 64'd9);
    push(ACT_SET, 8'd200, 8'd200, '0);
    push(ACT_LOOKUP, 8'd0, 8'd0, '0);
    push(ACT_LOOKUP, 8'd0, 8'd255, '0);
    drain();

    // Column order reinterprets the stored entries.
    write_reg(CFG_MAJOR_ORDER, 9'd1);
    write_reg(CFG_LINE_COUNT, 9'd511);
    write_reg(CFG_MINOR_COUNT, 9'd511);
    push(ACT_LOOKUP, 8'd3, 8'd0, '0);
    push(ACT_LOOKUP, 8'd0, 8'd3, '0);
    push(ACT_SET, 8'd4, 8'd1, 64'd44);
    push(ACT_LOOKUP, 8'd4, 8'd1, '0);
    drain();

    // Random phases over register settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MAJOR_ORDER, 9'($urandom_range(1)));
      write_reg(CFG_LINE_COUNT, line_opts[$urandom_range(5)]);
      write_reg(CFG_MINOR_COUNT, minor_opts[$urandom_range(5)]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int k = 0; k < 140; k++) begin
        push_random(13);
        // Stall the sink for a long stretch while requests keep coming.
        if (ph == 0 && k == 40) hold_asks++;
        // Pause the sender until every result is back.
        if (ph == 4 && k == 70) drain();
      end
      drain();
    end

    // Back to row order at full size, then a short mixed burst.
    write_reg(CFG_MAJOR_ORDER, 9'd0);
    write_reg(CFG_LINE_COUNT, 9'd256);
    write_reg(CFG_MINOR_COUNT, 9'd256);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    for (int k = 0; k < 40; k++) push_random(13);
    push(ACT_SET, 8'd255, 8'd15, '1);
    push(ACT_LOOKUP, 8'd255, 8'd15, '0);
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
